FILE: src/assert_macros.svh
// Assertion macros shared by the positional array list RTL.
// Needs nothing else; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PAL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pal assertion failed");
`define PAL_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("pal forbidden condition seen");
`else
`define PAL_ASSERT(lbl, clk, rst, prop)
`define PAL_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: src/pal_pkg.sv
// Constants, types and command codes of the positional array list.
// No dependencies; the interfaces and RTL modules refer to it by scoped names.
package pal_pkg;

  localparam int DEPTH  = 512;
  localparam int WORD_W = 32;
  localparam int POS_W  = 10;
  localparam int CMD_W  = 3;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  // fan-in of the first two levels of the removed-word gather tree
  localparam int GRP    = 16;
  localparam int L1_N   = (DEPTH + GRP - 1) / GRP;
  localparam int L2_N   = (L1_N + GRP - 1) / GRP;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_REM_HEAD = 3'd3,
    CMD_REM_TAIL = 3'd4,
    CMD_REM_POS  = 3'd5
  } cmd_e;

  // broadcast from the control to every cell
  typedef struct packed {
    logic  ins;   // accepted insert that passed its checks
    logic  rem;   // accepted remove that passed its checks
    cmp_t  pos;   // resolved target index
    cmp_t  cnt;   // entry count before the command
    word_t word;  // word to insert
  } cell_ctl_t;

endpackage

FILE: src/pal_if.sv
// Command and result channel interfaces of the positional array list.
// Depends on pal_pkg for payload types.
interface pal_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [pal_pkg::CMD_W-1:0]     cmd;
  pal_pkg::pos_t                 position;
  pal_pkg::word_t                entry_value;

  modport source (output valid, output cmd, output position, output entry_value,
                  input ready);
  modport sink   (input valid, input cmd, input position, input entry_value,
                  output ready);
endinterface

interface pal_res_if;
  logic           valid;
  logic           ready;
  pal_pkg::word_t removed_value;
  logic           error;
  pal_pkg::pos_t  entry_count;

  modport source (output valid, output removed_value, output error, output entry_count,
                  input ready);
  modport sink   (input valid, input removed_value, input error, input entry_count,
                  output ready);
endinterface

FILE: src/positional_array_list.sv
// Positional array list: ordered list of entry words with insert/remove anywhere.
// The result comes out of the three registered levels of the removed-word OR tree;
// result valid rises once the command beat has passed all three and holds until taken.
// Throughput: one command per cycle; the whole row of cells shifts together, and a
// waiting result holds the whole pipeline and the command side.
// Reset (rst, synchronous): clears the count and the result pipeline, not the entry words.
`include "assert_macros.svh"

module positional_array_list (
  input logic     clk,
  input logic     rst,
  pal_cmd_if.sink   command,
  pal_res_if.source result
);

  typedef struct packed {
    logic          error;
    pal_pkg::pos_t entry_count;
  } meta_t;

  pal_pkg::cnt_t      count;
  pal_pkg::cnt_t      count_next;
  pal_pkg::cmp_t      cnt_x;
  pal_pkg::cmp_t      pos_x;
  pal_pkg::cmp_t      tgt;
  logic               is_ins;
  logic               is_rem;
  logic               ins_ok;
  logic               rem_ok;
  logic               err;
  logic               acc;
  logic               adv;
  logic               v1;
  logic               v2;
  logic               v3;
  meta_t              m1;
  meta_t              m2;
  meta_t              m3;
  pal_pkg::cell_ctl_t ctl;
  pal_pkg::word_t     cell_data [pal_pkg::DEPTH];
  pal_pkg::word_t     cell_sel  [pal_pkg::DEPTH];
  pal_pkg::word_t     removed;

  // move the pipeline whenever the output slot is free or being emptied
  assign adv           = !v3 || result.ready;
  assign command.ready = adv && !rst;
  assign acc           = command.valid && command.ready;

  assign cnt_x = pal_pkg::cmp_t'(count);
  assign pos_x = pal_pkg::cmp_t'(command.position);

  // decode the command and resolve its target index
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    tgt    = '0;
    unique case (pal_pkg::cmd_e'(command.cmd))
      pal_pkg::CMD_INS_HEAD: begin
        is_ins = 1'b1;
      end
      pal_pkg::CMD_INS_TAIL: begin
        is_ins = 1'b1;
        tgt    = cnt_x;
      end
      pal_pkg::CMD_INS_POS: begin
        is_ins = 1'b1;
        tgt    = pos_x;
      end
      pal_pkg::CMD_REM_HEAD: begin
        is_rem = 1'b1;
      end
      pal_pkg::CMD_REM_TAIL: begin
        is_rem = 1'b1;
        tgt    = cnt_x - pal_pkg::cmp_t'(1);
      end
      pal_pkg::CMD_REM_POS: begin
        is_rem = 1'b1;
        tgt    = pos_x;
      end
      default: begin
      end
    endcase
  end

  // refuse a full insert, an empty remove or a target out of range
  assign ins_ok = is_ins && (count != pal_pkg::cnt_t'(pal_pkg::DEPTH)) && (tgt <= cnt_x);
  assign rem_ok = is_rem && (count != '0) && (tgt < cnt_x);
  assign err    = (is_ins && !ins_ok) || (is_rem && !rem_ok);

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + pal_pkg::cnt_t'(1);
    end else if (rem_ok) begin
      count_next = count - pal_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (acc) begin
      count <= count_next;
    end
  end

  // broadcast the command to the row
  assign ctl.ins  = acc && ins_ok;
  assign ctl.rem  = acc && rem_ok;
  assign ctl.pos  = tgt;
  assign ctl.cnt  = cnt_x;
  assign ctl.word = command.entry_value;

  for (genvar g = 0; g < pal_pkg::DEPTH; g++) begin : g_cell
    pal_pkg::word_t left;
    pal_pkg::word_t right;

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end

    if (g == pal_pkg::DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    pal_cell u_cell (
      .clk   (clk),
      .idx   (pal_pkg::idx_t'(g)),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .data  (cell_data[g]),
      .sel   (cell_sel[g])
    );
  end

  pal_gather u_gather (
    .clk     (clk),
    .adv     (adv),
    .sel     (cell_sel),
    .removed (removed)
  );

  // carry error and count alongside the gather tree
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1.error       <= err;
      m1.entry_count <= pal_pkg::pos_t'(count_next);
      m2             <= m1;
      m3             <= m2;
    end
  end

  assign result.valid         = v3;
  assign result.removed_value = removed;
  assign result.error         = m3.error;
  assign result.entry_count   = m3.entry_count;

  `PAL_NEVER(a_count_bound, clk, rst, count > pal_pkg::cnt_t'(pal_pkg::DEPTH))
  `PAL_ASSERT(a_ins_grows, clk, rst, ctl.ins |=> count == pal_pkg::cnt_t'($past(count) + 1'b1))
  `PAL_ASSERT(a_rem_shrinks, clk, rst, ctl.rem |=> count == pal_pkg::cnt_t'($past(count) - 1'b1))
  `PAL_ASSERT(a_idle_holds, clk, rst, !acc |=> $stable(count))
  `PAL_NEVER(a_err_no_word, clk, rst, v3 && m3.error && removed != '0)

endmodule

FILE: src/pal_cell.sv
// One list slot: holds a single entry word and shifts with its neighbors.
// Depends on pal_pkg for the control broadcast and word types.
module pal_cell (
  input  logic               clk,
  input  pal_pkg::idx_t      idx,
  input  pal_pkg::cell_ctl_t ctl,
  input  pal_pkg::word_t     left,
  input  pal_pkg::word_t     right,
  output pal_pkg::word_t     data,
  output pal_pkg::word_t     sel
);

  pal_pkg::cmp_t  ix;
  pal_pkg::cmp_t  ix_inc;
  pal_pkg::word_t data_next;

  assign ix     = pal_pkg::cmp_t'(idx);
  assign ix_inc = ix + pal_pkg::cmp_t'(1);

  // pick the next word: load, take from below, take from above, or hold
  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (ix == ctl.pos) begin
        data_next = ctl.word;
      end else if (ix > ctl.pos && ix <= ctl.cnt) begin
        data_next = left;
      end
    end else if (ctl.rem) begin
      if (ix >= ctl.pos && ix_inc < ctl.cnt) begin
        data_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // offer the current word to the gather tree when this slot is removed
  assign sel = (ctl.rem && ix == ctl.pos) ? data : '0;

endmodule

FILE: src/pal_gather.sv
// Registered OR tree that collects the removed word from the row of cells.
// Depends on pal_pkg for depth, group size and word type.
module pal_gather (
  input  logic           clk,
  input  logic           adv,
  input  pal_pkg::word_t sel [pal_pkg::DEPTH],
  output pal_pkg::word_t removed
);

  pal_pkg::word_t l1      [pal_pkg::L1_N];
  pal_pkg::word_t l2      [pal_pkg::L2_N];
  pal_pkg::word_t l1_next [pal_pkg::L1_N];
  pal_pkg::word_t l2_next [pal_pkg::L2_N];
  pal_pkg::word_t top_next;

  // first level: fold groups of cells
  always_comb begin
    for (int j = 0; j < pal_pkg::L1_N; j++) begin
      l1_next[j] = '0;
      for (int k = 0; k < pal_pkg::GRP; k++) begin
        if (j * pal_pkg::GRP + k < pal_pkg::DEPTH) begin
          l1_next[j] = l1_next[j] | sel[j * pal_pkg::GRP + k];
        end
      end
    end
  end

  // second level: fold groups of first-level words
  always_comb begin
    for (int j = 0; j < pal_pkg::L2_N; j++) begin
      l2_next[j] = '0;
      for (int k = 0; k < pal_pkg::GRP; k++) begin
        if (j * pal_pkg::GRP + k < pal_pkg::L1_N) begin
          l2_next[j] = l2_next[j] | l1[j * pal_pkg::GRP + k];
        end
      end
    end
  end

  // last level: fold what is left into the output word
  always_comb begin
    top_next = '0;
    for (int j = 0; j < pal_pkg::L2_N; j++) begin
      top_next = top_next | l2[j];
    end
  end

  // advance all levels together, hold on stall
  always_ff @(posedge clk) begin
    if (adv) begin
      l1      <= l1_next;
      l2      <= l2_next;
      removed <= top_next;
    end
  end

endmodule
